>>> sv/css_descendant_pseudo_colon_lookahead_assert.svh
// Assertion macros for the descendant/pseudo-colon lookahead scanner.
`ifndef CSS_DESCENDANT_PSEUDO_COLON_LOOKAHEAD_ASSERT_SVH
`define CSS_DESCENDANT_PSEUDO_COLON_LOOKAHEAD_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CSS_DPCL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CSS_DPCL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner assertion failed");

`endif

>>> sv/css_dpcl_pkg.sv
// Character codes and symbol codes for the descendant/pseudo-colon scanner.
package css_dpcl_pkg;

    localparam int CHAR_W = 21;

    localparam logic [CHAR_W-1:0] CH_TAB    = 21'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 21'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 21'h20;
    localparam logic [CHAR_W-1:0] CH_HASH   = 21'h23;
    localparam logic [CHAR_W-1:0] CH_STAR   = 21'h2A;
    localparam logic [CHAR_W-1:0] CH_DASH   = 21'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 21'h2E;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 21'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 21'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 21'h39;
    localparam logic [CHAR_W-1:0] CH_COLON  = 21'h3A;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 21'h3B;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 21'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 21'h5A;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 21'h5B;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 21'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 21'h7A;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 21'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 21'h7D;

    localparam logic SYM_DESCENDANT = 1'b0;
    localparam logic SYM_PSEUDO     = 1'b1;

    localparam int OFF_W = 10;

endpackage

>>> sv/css_descendant_pseudo_colon_lookahead.sv
// Lookahead scanner: descendant whitespace combinator versus pseudo-class colon.
// A verdict is registered and appears on the result port in the cycle after its character word is taken.
// Throughput: one character word per cycle while item_ready is high; the phase register updates once per word.
// A word is taken whenever the result register is empty or is being drained.
// Reset (rst_n low, asynchronous) returns the scan to idle and clears flags,
// counters and the result register.
module css_descendant_pseudo_colon_lookahead #(
    parameter int OFFSET_MAX = 1023
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic                              scan_start,
    input  logic                              recovery_valid,
    input  logic                              descendant_valid,
    input  logic                              pseudo_valid,
    input  logic [css_dpcl_pkg::CHAR_W-1:0]   char_code,
    input  logic                              at_end,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic                              accepted,
    output logic                              symbol,
    output logic [css_dpcl_pkg::OFF_W-1:0]    marked_offset
);
    import css_dpcl_pkg::*;

    `include "css_descendant_pseudo_colon_lookahead_assert.svh"

    localparam int CW = $clog2(OFFSET_MAX + 1);
    localparam logic [CW-1:0] OFF_LIMIT = CW'(OFFSET_MAX);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_D_WS,
        PH_D_COLON,
        PH_D_SEARCH,
        PH_P_WS,
        PH_P_COLON,
        PH_P_ADV,
        PH_P_SLASH,
        PH_P_STAR
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic            pseudo_reg, pseudo_next;
    logic            comment_reg, comment_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   mark_reg, mark_next;

    logic            result_valid_reg;
    logic            accepted_reg;
    logic            symbol_reg;
    logic [OFF_W-1:0] offset_reg;

    logic [CHAR_W-1:0] c;
    logic c_ws, c_alnum, c_lead, c_colon, c_semi, c_lbrace, c_rbrace, c_slash, c_star;
    logic [CW-1:0]   count_base, count_bump, loop_mark, off_val;
    logic [CW+OFF_W-1:0] off_ext;
    logic            item_fire, emit, acc, sym;
    logic            do_reject, do_accept, do_loop;

    assign c = at_end ? '0 : char_code;

    assign c_ws     = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    assign c_alnum  = (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UPPER_A && c <= CH_UPPER_Z)
                   || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    assign c_lead   = (c == CH_HASH) || (c == CH_DOT) || (c == CH_LBRACK) || (c == CH_DASH)
                   || (c == CH_STAR) || c_alnum;
    assign c_colon  = (c == CH_COLON);
    assign c_semi   = (c == CH_SEMI);
    assign c_lbrace = (c == CH_LBRACE);
    assign c_rbrace = (c == CH_RBRACE);
    assign c_slash  = (c == CH_SLASH);
    assign c_star   = (c == CH_STAR);

    assign count_base = scan_start ? '0 : count_reg;
    assign count_bump = (count_base < OFF_LIMIT) ? count_base + 1'b1 : count_base;
    assign loop_mark  = (phase_reg == PH_P_COLON) ? count_reg : mark_reg;

    assign item_ready = !result_valid_reg || result_ready;
    assign item_fire  = item_valid && item_ready;

    always_comb
    begin
        phase_next   = phase_reg;
        pseudo_next  = pseudo_reg;
        comment_next = comment_reg;
        count_next   = count_reg;
        mark_next    = mark_reg;
        do_reject    = 1'b0;
        do_accept    = 1'b0;
        do_loop      = 1'b0;
        sym          = SYM_DESCENDANT;
        off_val      = '0;
        if (scan_start)
        begin
            pseudo_next  = pseudo_valid;
            comment_next = 1'b0;
            count_next   = '0;
            mark_next    = '0;
            if (recovery_valid)
                do_reject = 1'b1;
            else if (c_ws && descendant_valid)
            begin
                count_next = count_bump;
                phase_next = PH_D_WS;
            end
            else if (pseudo_valid && c_ws)
            begin
                count_next = count_bump;
                phase_next = PH_P_WS;
            end
            else if (pseudo_valid && c_colon)
            begin
                count_next = count_bump;
                phase_next = PH_P_COLON;
            end
            else
                do_reject = 1'b1;
        end
        else
        begin
            unique case (phase_reg) inside
                PH_IDLE:
                begin
                end
                PH_D_WS:
                begin
                    if (c_ws)
                        count_next = count_bump;
                    else
                    begin
                        mark_next = count_reg;
                        if (c_lead)
                        begin
                            do_accept = 1'b1;
                            off_val   = count_reg;
                        end
                        else if (c_colon)
                        begin
                            count_next = count_bump;
                            phase_next = PH_D_COLON;
                        end
                        else
                            do_reject = 1'b1;
                    end
                end
                PH_D_COLON, PH_D_SEARCH:
                begin
                    if (phase_reg == PH_D_COLON && c_ws)
                        do_reject = 1'b1;
                    else if (at_end || c_semi || c_rbrace)
                        do_reject = 1'b1;
                    else if (c_lbrace)
                    begin
                        do_accept = 1'b1;
                        off_val   = mark_reg;
                    end
                    else
                    begin
                        count_next = count_bump;
                        phase_next = PH_D_SEARCH;
                    end
                end
                PH_P_WS:
                begin
                    if (pseudo_reg && c_ws)
                        count_next = count_bump;
                    else if (pseudo_reg && c_colon)
                    begin
                        count_next = count_bump;
                        phase_next = PH_P_COLON;
                    end
                    else
                        do_reject = 1'b1;
                end
                PH_P_COLON:
                begin
                    if (c_colon)
                        do_reject = 1'b1;
                    else
                    begin
                        mark_next    = count_reg;
                        comment_next = 1'b0;
                        do_loop      = 1'b1;
                    end
                end
                PH_P_ADV:
                begin
                    if (c_lbrace && !comment_reg)
                    begin
                        do_accept = 1'b1;
                        sym       = SYM_PSEUDO;
                        off_val   = mark_reg;
                    end
                    else if (c_slash && !comment_reg)
                    begin
                        count_next = count_bump;
                        phase_next = PH_P_SLASH;
                    end
                    else if (c_star && comment_reg)
                    begin
                        count_next = count_bump;
                        phase_next = PH_P_STAR;
                    end
                    else
                        do_loop = 1'b1;
                end
                PH_P_SLASH:
                begin
                    if (c_star)
                        comment_next = 1'b1;
                    do_loop = 1'b1;
                end
                PH_P_STAR:
                begin
                    if (c_slash)
                        comment_next = 1'b0;
                    do_loop = 1'b1;
                end
                default:
                    phase_next = PH_IDLE;
            endcase
        end

        if (do_loop)
        begin
            if (at_end)
            begin
                do_accept = 1'b1;
                sym       = SYM_PSEUDO;
                off_val   = loop_mark;
            end
            else if (c_semi || c_rbrace)
                do_reject = 1'b1;
            else
            begin
                count_next = count_bump;
                phase_next = PH_P_ADV;
            end
        end

        emit = do_accept || do_reject;
        acc  = do_accept;
        if (do_reject)
        begin
            sym     = SYM_DESCENDANT;
            off_val = '0;
        end
        if (emit)
            phase_next = PH_IDLE;
    end

    assign off_ext = {{OFF_W{1'b0}}, off_val};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            pseudo_reg       <= 1'b0;
            comment_reg      <= 1'b0;
            count_reg        <= '0;
            mark_reg         <= '0;
            result_valid_reg <= 1'b0;
            accepted_reg     <= 1'b0;
            symbol_reg       <= SYM_DESCENDANT;
            offset_reg       <= '0;
        end
        else
        begin
            if (item_fire)
            begin
                phase_reg   <= phase_next;
                pseudo_reg  <= pseudo_next;
                comment_reg <= comment_next;
                count_reg   <= count_next;
                mark_reg    <= mark_next;
            end
            if (item_fire && emit)
            begin
                result_valid_reg <= 1'b1;
                accepted_reg     <= acc;
                symbol_reg       <= sym;
                offset_reg       <= off_ext[OFF_W-1:0];
            end
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    assign result_valid  = result_valid_reg;
    assign accepted      = accepted_reg;
    assign symbol        = symbol_reg;
    assign marked_offset = offset_reg;

    `CSS_DPCL_ASSERT_NXT(a_idle_holds,
        item_fire && !scan_start && phase_reg == PH_IDLE, phase_reg == PH_IDLE)
    `CSS_DPCL_ASSERT_IMP(a_reject_clean,
        result_valid_reg && !accepted_reg, symbol_reg == SYM_DESCENDANT && offset_reg == '0)
    `CSS_DPCL_ASSERT_IMP(a_count_sat, 1'b1, count_reg <= OFF_LIMIT && mark_reg <= count_reg)
    `CSS_DPCL_ASSERT_NXT(a_verdict_idle, item_fire && emit, phase_reg == PH_IDLE && result_valid_reg)

endmodule
